// ===== design/pursuit_robot_move_selector_assert.svh =====
// Assertion macros used by the pursuit robot move selector checker.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef PURSUIT_ROBOT_MOVE_SELECTOR_ASSERT_SVH
`define PURSUIT_ROBOT_MOVE_SELECTOR_ASSERT_SVH

// Checked only while reset is released.
`define PMSEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define PMSEL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/pmsel_pkg.sv =====
// Shared types, widths and codes of the pursuit robot move selector.
// No dependencies; every other design file but the assertion header imports this package.
package pmsel_pkg;

  localparam int CoordBits = 11;
  localparam int PixW      = 11;
  localparam int TolW      = 16;
  localparam int RotW      = 8;
  localparam int SecW      = 16;
  localparam int MoveW     = 3;
  localparam int HoldW     = 11;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam int DiffW  = CoordBits + 1;
  localparam int CtrW   = ((CoordBits > PixW - 1) ? CoordBits : PixW - 1) + 1;
  localparam int CrossW = 2 * DiffW;
  localparam int D2W    = CrossW - 1;
  localparam int LhsW   = 2 * CrossW - 2;
  localparam int Tol2W  = 2 * TolW;
  localparam int RhsW   = Tol2W + D2W;
  localparam int CmpW   = (LhsW + 16 > RhsW) ? LhsW + 16 : RhsW;
  localparam int CtrPW  = CtrW + DiffW + 1;
  localparam int MulW   = (CrossW > Tol2W + 1) ? CrossW : Tol2W + 1;
  localparam int ProdW  = 2 * MulW;
  localparam int DistW  = (CoordBits > PixW) ? CoordBits : PixW;

  localparam int InFieldsW = 6 * CoordBits + SecW;
  localparam int InW       = ((InFieldsW + 7) / 8) * 8;
  localparam int InUserW   = 3;
  localparam int OutW      = ((MoveW + HoldW + 7) / 8) * 8;

  typedef enum logic [MoveW-1:0] {
    MV_FORWARD  = 3'd0,
    MV_BACKWARD = 3'd1,
    MV_RIGHT    = 3'd2,
    MV_LEFT     = 3'd3,
    MV_STOP     = 3'd4
  } move_e;

  localparam logic [HoldW-1:0] HoldStop   = 11'd100;
  localparam logic [HoldW-1:0] HoldTurn   = 11'd400;
  localparam logic [HoldW-1:0] HoldAttack = 11'd1200;
  localparam logic [HoldW-1:0] HoldCTurn  = 11'd300;
  localparam logic [HoldW-1:0] HoldPush   = 11'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_ALIGN_TOL    = 3'd2,
    CFG_IMPACT_DIST  = 3'd3,
    CFG_STILL_DIST   = 3'd4,
    CFG_MAX_ROTATE   = 3'd5
  } cfg_idx_e;

  // Multiply sequence, one product per step.
  typedef enum logic [3:0] {
    OP_DX_VY    = 4'd0,
    OP_DY_VX    = 4'd1,
    OP_DX_VX    = 4'd2,
    OP_DY_VY    = 4'd3,
    OP_DX_DX    = 4'd4,
    OP_DY_DY    = 4'd5,
    OP_TOL_TOL  = 4'd6,
    OP_CROSS_SQ = 4'd7,
    OP_TOL2_D2  = 4'd8,
    OP_CX_VY    = 4'd9,
    OP_CY_VX    = 4'd10,
    OP_DONE     = 4'd11
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_MUL    = 4'b0100,
    S_DECIDE = 4'b1000
  } state_e;

  typedef struct packed {
    logic [PixW-1:0] frame_width;
    logic [PixW-1:0] frame_height;
    logic [TolW-1:0] align_tol;
    logic [PixW-1:0] impact_dist;
    logic [PixW-1:0] still_dist;
    logic [RotW-1:0] max_rotate;
  } cfg_t;

  // First field of the beat sits in the lowest bits.
  typedef struct packed {
    logic [SecW-1:0]      now_seconds;
    logic [CoordBits-1:0] tip_y;
    logic [CoordBits-1:0] tip_x;
    logic [CoordBits-1:0] self_y;
    logic [CoordBits-1:0] self_x;
    logic [CoordBits-1:0] opp_y;
    logic [CoordBits-1:0] opp_x;
  } in_item_t;

  typedef struct packed {
    move_e            move;
    logic [HoldW-1:0] hold_ms;
    logic             last;
  } beat_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic mul_en;
    op_e  op;
    logic decide;
  } dp_cmd_t;

  typedef struct packed {
    logic opp_found;
    logic self_found;
    logic tip_found;
    logic ob_empty;
  } dp_status_t;

endpackage

// ===== design/pmsel_cfg_regs.sv =====
// Configuration register bank of the move selector.
// Depends on pmsel_pkg for the register indices and the cfg_t bundle.
module pmsel_cfg_regs import pmsel_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_data_i[PixW-1:0];
        CFG_FRAME_HEIGHT: cfg_d.frame_height = cfg_data_i[PixW-1:0];
        CFG_ALIGN_TOL:    cfg_d.align_tol    = cfg_data_i[TolW-1:0];
        CFG_IMPACT_DIST:  cfg_d.impact_dist  = cfg_data_i[PixW-1:0];
        CFG_STILL_DIST:   cfg_d.still_dist   = cfg_data_i[PixW-1:0];
        CFG_MAX_ROTATE:   cfg_d.max_rotate   = cfg_data_i[RotW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= PixW'(640);
      cfg_q.frame_height <= PixW'(480);
      cfg_q.align_tol    <= TolW'(205);
      cfg_q.impact_dist  <= PixW'(40);
      cfg_q.still_dist   <= PixW'(15);
      cfg_q.max_rotate   <= RotW'(4);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== design/pmsel_ctrl.sv =====
// Controller state machine of the move selector: sequences load, checks,
// the shared multiplier and the decision. Depends on pmsel_pkg.
module pmsel_ctrl import pmsel_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    cmd_o.load    = 1'b0;
    cmd_o.eval    = 1'b0;
    cmd_o.mul_en  = 1'b0;
    cmd_o.op      = op_q;
    cmd_o.decide  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!status_i.opp_found) begin
          state_d = S_DECIDE;
        end else if (!status_i.self_found || !status_i.tip_found) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_MUL;
          op_d    = OP_DX_VY;
        end
      end
      S_MUL: begin
        if (op_q == OP_DONE) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.mul_en = 1'b1;
          op_d         = op_e'(op_q + 4'd1);
        end
      end
      S_DECIDE: begin
        // The result buffer takes a whole frame's beats at once.
        if (status_i.ob_empty) begin
          cmd_o.decide = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_DX_VY;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ===== design/pmsel_datapath.sv =====
// Datapath of the move selector: frame registers, tracking state, one shared
// signed multiplier with accumulators, decision logic and result buffer.
// Depends on pmsel_pkg.
module pmsel_datapath import pmsel_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  in_item_t           item_i,
  input  logic [InUserW-1:0] found_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output beat_t              out_beat_o
);

  function automatic logic [CoordBits-1:0] abs_diff(input logic [CoordBits-1:0] a,
                                                     input logic [CoordBits-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Frame registers.
  in_item_t item_q;
  logic     opp_q, self_q, tip_q;

  // Tracking state.
  logic [CoordBits-1:0] prev_x_q, prev_y_q;
  logic                 contact_seen_q, rotating_q, attack_back_q, stuck_q;
  logic [SecW-1:0]      rot_start_q;

  // Operands and products.
  logic signed [DiffW-1:0]  dx_q, dy_q, vx_q, vy_q;
  logic signed [CtrW-1:0]   cx_q, cy_q;
  logic signed [MulW-1:0]   a_m, b_m;
  logic signed [ProdW-1:0]  prod, p_q;
  logic                     acc_q;
  op_e                      kd_q;
  logic signed [CrossW-1:0] cross_q, dot_q, cross_abs;
  logic [D2W-1:0]           d2_q;
  logic [Tol2W-1:0]         tol2_q;
  logic [LhsW-1:0]          lhs_q;
  logic [RhsW-1:0]          rhs_q;
  logic signed [CtrPW-1:0]  ctr_q;

  // Decision.
  logic            still, contact, aligned, rot_go, ctr_right, cross_neg, dot_neg;
  logic [SecW-1:0] start, elapsed;
  move_e           turn;
  beat_t           b0, b1;
  logic [1:0]      n_beats;

  // Result buffer.
  logic [1:0] ob_cnt_q;
  beat_t      ob0_q, ob1_q;

  assign status_o.opp_found  = opp_q;
  assign status_o.self_found = self_q;
  assign status_o.tip_found  = tip_q;
  assign status_o.ob_empty   = (ob_cnt_q == 2'd0);

  assign still = (DistW'(abs_diff(item_q.self_x, prev_x_q)) < DistW'(cfg_i.still_dist)) &&
                 (DistW'(abs_diff(item_q.self_y, prev_y_q)) < DistW'(cfg_i.still_dist));
  assign contact = (DistW'(abs_diff(item_q.self_x, item_q.opp_x)) < DistW'(cfg_i.impact_dist)) &&
                   (DistW'(abs_diff(item_q.self_y, item_q.opp_y)) < DistW'(cfg_i.impact_dist));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
      opp_q  <= found_i[0];
      self_q <= found_i[1];
      tip_q  <= found_i[2];
    end
    if (cmd_i.eval) begin
      // Image rows grow downward, so y differences are flipped to point up.
      dx_q <= $signed({1'b0, item_q.opp_x}) - $signed({1'b0, item_q.self_x});
      dy_q <= $signed({1'b0, item_q.self_y}) - $signed({1'b0, item_q.opp_y});
      vx_q <= $signed({1'b0, item_q.tip_x}) - $signed({1'b0, item_q.self_x});
      vy_q <= $signed({1'b0, item_q.self_y}) - $signed({1'b0, item_q.tip_y});
      cx_q <= $signed(CtrW'(cfg_i.frame_width[PixW-1:1])) - $signed(CtrW'(item_q.self_x));
      cy_q <= $signed(CtrW'(item_q.self_y)) - $signed(CtrW'(cfg_i.frame_height[PixW-1:1]));
    end
  end

  // Tracking state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q       <= '0;
      prev_y_q       <= '0;
      contact_seen_q <= 1'b0;
      stuck_q        <= 1'b0;
      rotating_q     <= 1'b0;
      rot_start_q    <= '0;
      attack_back_q  <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        stuck_q <= opp_q && self_q && tip_q && contact && contact_seen_q && still;
        if (opp_q && self_q) begin
          prev_x_q <= item_q.self_x;
          prev_y_q <= item_q.self_y;
        end
        if (opp_q && self_q && tip_q) begin
          contact_seen_q <= contact;
        end
      end
      if (cmd_i.decide && opp_q && !stuck_q) begin
        attack_back_q <= dot_neg;
        rotating_q    <= rot_go;
        if (!aligned) begin
          rot_start_q <= start;
        end
      end
    end
  end

  assign cross_abs = cross_q[CrossW-1] ? -cross_q : cross_q;

  always_comb begin
    case (cmd_i.op)
      OP_DX_VY:    begin a_m = MulW'(dx_q); b_m = MulW'(vy_q); end
      OP_DY_VX:    begin a_m = MulW'(dy_q); b_m = MulW'(vx_q); end
      OP_DX_VX:    begin a_m = MulW'(dx_q); b_m = MulW'(vx_q); end
      OP_DY_VY:    begin a_m = MulW'(dy_q); b_m = MulW'(vy_q); end
      OP_DX_DX:    begin a_m = MulW'(dx_q); b_m = MulW'(dx_q); end
      OP_DY_DY:    begin a_m = MulW'(dy_q); b_m = MulW'(dy_q); end
      OP_TOL_TOL: begin
        a_m = $signed(MulW'(cfg_i.align_tol));
        b_m = $signed(MulW'(cfg_i.align_tol));
      end
      OP_CROSS_SQ: begin
        a_m = $signed(MulW'(cross_abs[CrossW-2:0]));
        b_m = $signed(MulW'(cross_abs[CrossW-2:0]));
      end
      OP_TOL2_D2: begin
        a_m = $signed(MulW'(tol2_q));
        b_m = $signed(MulW'(d2_q));
      end
      OP_CX_VY:    begin a_m = MulW'(cx_q); b_m = MulW'(vy_q); end
      OP_CY_VX:    begin a_m = MulW'(cy_q); b_m = MulW'(vx_q); end
      default:     begin a_m = '0; b_m = '0; end
    endcase
  end

  assign prod = a_m * b_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
      kd_q  <= OP_DX_VY;
    end else begin
      acc_q <= cmd_i.mul_en;
      kd_q  <= cmd_i.op;
    end
  end

  // Each product is registered in p_q, then folded into its accumulator.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_q <= prod;
    end
    if (acc_q) begin
      case (kd_q)
        OP_DX_VY:    cross_q <= CrossW'(p_q);
        OP_DY_VX:    cross_q <= cross_q - CrossW'(p_q);
        OP_DX_VX:    dot_q   <= CrossW'(p_q);
        OP_DY_VY:    dot_q   <= dot_q + CrossW'(p_q);
        OP_DX_DX:    d2_q    <= D2W'(p_q);
        OP_DY_DY:    d2_q    <= d2_q + D2W'(p_q);
        OP_TOL_TOL:  tol2_q  <= Tol2W'(p_q);
        OP_CROSS_SQ: lhs_q   <= LhsW'(p_q);
        OP_TOL2_D2:  rhs_q   <= RhsW'(p_q);
        OP_CX_VY:    ctr_q   <= CtrPW'(p_q);
        OP_CY_VX:    ctr_q   <= ctr_q - CtrPW'(p_q);
        default: ;
      endcase
    end
  end

  // Aligned when (|cross| * 256)^2 < tol^2 * |d|^2; coincident points never are.
  assign aligned   = (d2_q != '0) && (CmpW'({lhs_q, 16'h0000}) < CmpW'(rhs_q));
  assign cross_neg = cross_q[CrossW-1];
  assign dot_neg   = dot_q[CrossW-1];
  assign turn      = (cross_neg ^ dot_neg) ? MV_LEFT : MV_RIGHT;
  assign start     = rotating_q ? rot_start_q : item_q.now_seconds;
  assign elapsed   = item_q.now_seconds - start;
  assign rot_go    = !aligned && (elapsed < SecW'(cfg_i.max_rotate));
  assign ctr_right = !ctr_q[CtrPW-1] ^ attack_back_q;

  always_comb begin
    b1 = '{move: attack_back_q ? MV_BACKWARD : MV_FORWARD, hold_ms: HoldPush, last: 1'b1};
    n_beats = 2'd1;
    if (!opp_q) begin
      b0 = '{move: MV_STOP, hold_ms: HoldStop, last: 1'b1};
    end else if (stuck_q) begin
      b0 = '{move: ctr_right ? MV_RIGHT : MV_LEFT, hold_ms: HoldCTurn, last: 1'b0};
      n_beats = 2'd2;
    end else if (rot_go) begin
      b0 = '{move: turn, hold_ms: HoldTurn, last: 1'b1};
    end else begin
      b0 = '{move: dot_neg ? MV_BACKWARD : MV_FORWARD, hold_ms: HoldAttack, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_cnt_q <= 2'd0;
    end else if (cmd_i.decide) begin
      ob_cnt_q <= n_beats;
    end else if ((ob_cnt_q != 2'd0) && out_ready_i) begin
      ob_cnt_q <= ob_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      ob0_q <= b0;
      ob1_q <= b1;
    end else if ((ob_cnt_q != 2'd0) && out_ready_i) begin
      ob0_q <= ob1_q;
    end
  end

  assign out_valid_o = (ob_cnt_q != 2'd0);
  assign out_beat_o  = ob0_q;

endmodule

// ===== design/pursuit_robot_move_selector.sv =====
// Sequence: a full frame is loaded and checked, then runs the eleven products one
// per cycle through the single shared multiplier before the decision, which waits
// for an empty result buffer; a frame without an opponent skips the products, and
// one without body or tip returns to idle after the checks. A new frame is taken only while idle.
// Reset: rst_ni is asynchronous and active low; it restores the register
// defaults and clears the tracking state and the result buffer.
module pursuit_robot_move_selector import pmsel_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Frame input.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata from bit 0: opp_x, opp_y, self_x, self_y, tip_x, tip_y, now_seconds, zero fill.
  input  logic [InW-1:0]      s_axis_tdata,
  // tuser from bit 0: opp_found, self_found, tip_found.
  input  logic [InUserW-1:0]  s_axis_tuser,
  // Drive command output.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata from bit 0: move, hold_ms, zero fill.
  output logic [OutW-1:0]     m_axis_tdata,
  output logic                m_axis_tlast,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  in_item_t   item;
  beat_t      beat;

  // The frame fields sit packed from bit 0; the fill bits above are ignored.
  assign item = in_item_t'(s_axis_tdata[InFieldsW-1:0]);

  pmsel_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The controller takes one frame at a time; the result buffer in the
  // datapath lets a new frame enter while earlier beats wait on the output.
  pmsel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // A stuck contact gives two beats (ring-centre turn, then a push); every
  // other emitting frame gives one beat marked last.
  pmsel_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .item_i      (item),
    .found_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (beat)
  );

  assign m_axis_tdata = OutW'({beat.hold_ms, beat.move});
  assign m_axis_tlast = beat.last;

endmodule

// ===== design/pmsel_checker.sv =====
// Port-level checker for the pursuit robot move selector, bound to the top.
// Depends on pmsel_pkg and pursuit_robot_move_selector_assert.svh.
module pmsel_checker import pmsel_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InW-1:0]      s_axis_tdata,
  input logic [InUserW-1:0]  s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutW-1:0]     m_axis_tdata,
  input logic                m_axis_tlast,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i
);

  `include "pursuit_robot_move_selector_assert.svh"

  logic [MoveW-1:0] mv;
  logic [HoldW-1:0] hold;

  assign mv   = m_axis_tdata[MoveW-1:0];
  assign hold = m_axis_tdata[MoveW+HoldW-1:MoveW];

  `PMSEL_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result beat changed while stalled")

  // Each command carries the hold time of its own kind.
  `PMSEL_ASSERT(a_hold_match, m_axis_tvalid |-> (mv == MV_STOP && hold == HoldStop && m_axis_tlast) || ((mv == MV_RIGHT || mv == MV_LEFT) && (hold == HoldTurn || hold == HoldCTurn)) || ((mv == MV_FORWARD || mv == MV_BACKWARD) && (hold == HoldAttack || hold == HoldPush) && m_axis_tlast), "move and hold time disagree")

  // The contact turn is followed at once by its push.
  `PMSEL_ASSERT(a_push_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast && hold == HoldPush, "contact turn not followed by push")

  `PMSEL_ASSERT(a_one_frame, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "frame accepted while one is being evaluated")

  `PMSEL_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "result beat offered during reset")

endmodule

bind pursuit_robot_move_selector pmsel_checker u_pmsel_checker (.*);

// ===== dv/tb_pursuit_robot_move_selector.sv =====
// Self-checking testbench for the pursuit robot move selector: frames of detections
// go in on the input stream and the drive commands are checked against a predictor.
// Depends on pmsel_pkg and the pursuit_robot_move_selector RTL only.
module tb_pursuit_robot_move_selector;
  import pmsel_pkg::*;

  localparam int ClkHalf      = 5;
  localparam int TimeoutTicks = 6_000_000;
  // A frame that yields no command may still be in flight when the last
  // planned command has arrived.
  localparam int DrainCycles  = 24;
  localparam int NumPhases    = 6;
  localparam int PhaseFrames  = 300;
  localparam int CoordMax     = (1 << CoordBits) - 1;

  // Detection flags as carried on tuser: opponent in bit 0, body, then tip.
  localparam logic [InUserW-1:0] SeenAll    = 3'b111;
  localparam logic [InUserW-1:0] SeenNoOpp  = 3'b110;
  localparam logic [InUserW-1:0] SeenNoSelf = 3'b101;
  localparam logic [InUserW-1:0] SeenNoTip  = 3'b011;
  // Register indexes past the end of the map, which the block must ignore.
  localparam int CfgFirstSpare = CFG_MAX_ROTATE + 1;

  typedef struct {
    logic [InUserW-1:0] seen;
    in_item_t           pos;
  } frame_t;

  typedef struct {
    move_e            mv;
    logic [HoldW-1:0] hold;
    logic             last;
  } cmd_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InW-1:0]      s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  pursuit_robot_move_selector DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Frames waiting to be sent, and drive commands the predictor has planned
  // but the block has not yet delivered.
  frame_t frame_queue[$];
  cmd_t   planned_cmds[$];

  // Register shadow, starting from the reset values.
  int ring_w    = 640;
  int ring_h    = 480;
  int tol       = 205;
  int impact    = 40;
  int still_lim = 15;
  int rot_limit = 4;

  // Tracking state of the robot as the predictor sees it.
  int              prev_x     = 0;
  int              prev_y     = 0;
  bit              in_contact = 1'b0;
  bit              spinning   = 1'b0;
  logic [SecW-1:0] spin_start = '0;
  bit              backing    = 1'b0;

  // Handshake bookkeeping between the monitor and the two drivers.
  bit frame_taken = 1'b0;
  bit cmd_taken   = 1'b0;
  int frame_gap   = 0;
  int cmd_stall   = 0;
  bit in_steady   = 1'b0;
  bit out_steady  = 1'b0;

  int err_count      = 0;
  int frames_seen    = 0;
  int cmds_seen      = 0;
  int pushes_planned = 0;
  int cfg_writes     = 0;

  // Scene that the random frames evolve from.
  int sc_sx, sc_sy, sc_ox, sc_oy, sc_now;
  bit sc_close;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_px(int v);
    return (v < 0) ? 0 : ((v > CoordMax) ? CoordMax : v);
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Idle cycles before the next beat; none at all while a side runs steady.
  function automatic int draw_gap(bit steady);
    return steady ? 0 : int'($urandom_range(0, 3));
  endfunction

  function automatic void push_cmd(move_e mv, logic [HoldW-1:0] hold, logic last);
    cmd_t c;
    c.mv   = mv;
    c.hold = hold;
    c.last = last;
    planned_cmds.push_back(c);
  endfunction

  // Works out the drive commands of one accepted frame and advances the
  // tracking state exactly as the block must.
  function automatic void plan_commands(logic [InUserW-1:0] seen, in_item_t pos);
    longint          ox, oy, sx, sy, tx, ty, vx, vy, dx, dy, cr, dt, cx, cy;
    longint unsigned d2;
    logic [127:0]    lean, reach;
    logic            stuck, aligned, right;
    move_e           turn;
    logic [SecW-1:0] elapsed;
    ox = pos.opp_x;
    oy = pos.opp_y;
    sx = pos.self_x;
    sy = pos.self_y;
    tx = pos.tip_x;
    ty = pos.tip_y;
    // No opponent: stop and leave everything as it was.
    if (!seen[0]) begin
      push_cmd(MV_STOP, HoldStop, 1'b1);
      return;
    end
    if (!seen[1]) return;
    stuck = magnitude(sx - prev_x) < still_lim && magnitude(sy - prev_y) < still_lim;
    prev_x = int'(sx);
    prev_y = int'(sy);
    // Without the tip only the body position moves on.
    if (!seen[2]) return;
    // Image rows run downward, so y differences are taken the other way round.
    vx = tx - sx;
    vy = sy - ty;
    if (magnitude(sx - ox) < impact && magnitude(sy - oy) < impact) begin
      if (in_contact) begin
        if (stuck) begin
          // Held contact while not moving: turn toward the ring centre, then push.
          cx = ring_w / 2 - sx;
          cy = sy - ring_h / 2;
          right = (cx * vy - cy * vx) >= 0;
          if (backing) right = !right;
          push_cmd(right ? MV_RIGHT : MV_LEFT, HoldCTurn, 1'b0);
          push_cmd(backing ? MV_BACKWARD : MV_FORWARD, HoldPush, 1'b1);
          pushes_planned++;
          return;
        end
      end else begin
        in_contact = 1'b1;
      end
    end else begin
      in_contact = 1'b0;
    end
    dx = ox - sx;
    dy = sy - oy;
    cr = dx * vy - dy * vx;
    dt = dx * vx + dy * vy;
    d2 = dx * dx + dy * dy;
    // Aligned when the tip's distance from the body-opponent line, times 256,
    // stays under the tolerance; squared on both sides to stay exact.
    lean  = 128'(magnitude(cr)) << 8;
    lean  = lean * lean;
    reach = 128'(tol) * 128'(tol) * 128'(d2);
    aligned = (d2 != 0) && (lean < reach);
    if (cr >= 0) turn = (dt >= 0) ? MV_RIGHT : MV_LEFT;
    else turn = (dt >= 0) ? MV_LEFT : MV_RIGHT;
    backing = dt < 0;
    if (!aligned) begin
      if (!spinning) spin_start = pos.now_seconds;
      elapsed = pos.now_seconds - spin_start;
      if (elapsed < rot_limit) begin
        spinning = 1'b1;
        push_cmd(turn, HoldTurn, 1'b1);
        return;
      end
    end
    spinning = 1'b0;
    push_cmd(backing ? MV_BACKWARD : MV_FORWARD, HoldAttack, 1'b1);
  endfunction

  function automatic frame_t mk_frame(logic [InUserW-1:0] seen, int ox, int oy, int sx,
                                      int sy, int tx, int ty, int now);
    frame_t fr;
    fr.seen            = seen;
    fr.pos.opp_x       = CoordBits'(clamp_px(ox));
    fr.pos.opp_y       = CoordBits'(clamp_px(oy));
    fr.pos.self_x      = CoordBits'(clamp_px(sx));
    fr.pos.self_y      = CoordBits'(clamp_px(sy));
    fr.pos.tip_x       = CoordBits'(clamp_px(tx));
    fr.pos.tip_y       = CoordBits'(clamp_px(ty));
    fr.pos.now_seconds = SecW'(now);
    return fr;
  endfunction

  // Next frame of a slowly moving scene. Most frames are complete and coherent
  // so that contact, stuck pushes and the rotation timer are reached; a few
  // are pure noise or lack one of the detections.
  function automatic frame_t scene_frame();
    frame_t             fr;
    int                 pick, m, tx, ty;
    logic [InUserW-1:0] seen;
    if ($urandom_range(0, 99) < 12) begin
      fr.seen = InUserW'($urandom);
      fr.pos  = InFieldsW'({$urandom, $urandom, $urandom});
      return fr;
    end
    if ($urandom_range(0, 1) != 0) begin
      sc_sx = clamp_px(sc_sx + jitter(40));
      sc_sy = clamp_px(sc_sy + jitter(40));
    end else begin
      sc_sx = clamp_px(sc_sx + jitter(3));
      sc_sy = clamp_px(sc_sy + jitter(3));
    end
    if ($urandom_range(0, 5) == 0) sc_close = !sc_close;
    if (sc_close) begin
      sc_ox = clamp_px(sc_sx + jitter(45));
      sc_oy = clamp_px(sc_sy + jitter(45));
    end else if ($urandom_range(0, 9) == 0) begin
      sc_ox = $urandom_range(0, CoordMax);
      sc_oy = $urandom_range(0, CoordMax);
    end else begin
      sc_ox = clamp_px(sc_ox + jitter(25));
      sc_oy = clamp_px(sc_oy + jitter(25));
    end
    // Tip on or near the line to the opponent, in front or behind, or anywhere near the body.
    m = $urandom_range(1, 2);
    if ($urandom_range(0, 1) != 0) m = -m;
    pick = $urandom_range(0, 3);
    tx = sc_sx + (sc_ox - sc_sx) * m / 8;
    ty = sc_sy + (sc_oy - sc_sy) * m / 8;
    if (pick < 2) begin
      tx += jitter(1);
      ty += jitter(1);
    end else if (pick == 2) begin
      tx = sc_sx + jitter(40);
      ty = sc_sy + jitter(40);
    end
    if ($urandom_range(0, 99) == 0) sc_now = $urandom_range(0, 65535);
    else sc_now = (sc_now + $urandom_range(0, 2)) & 16'hFFFF;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       seen = SeenNoOpp;
      1:       seen = SeenNoSelf;
      2:       seen = SeenNoTip;
      default: seen = SeenAll;
    endcase
    return mk_frame(seen, sc_ox, sc_oy, sc_sx, sc_sy, tx, ty, sc_now);
  endfunction

  // One register write over the configuration channel; the shadow follows
  // once the write has been accepted.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (cfg_idx_e'(idx))
      CFG_FRAME_WIDTH:  ring_w    = val[PixW-1:0];
      CFG_FRAME_HEIGHT: ring_h    = val[PixW-1:0];
      CFG_ALIGN_TOL:    tol       = val[TolW-1:0];
      CFG_IMPACT_DIST:  impact    = val[PixW-1:0];
      CFG_STILL_DIST:   still_lim = val[PixW-1:0];
      CFG_MAX_ROTATE:   rot_limit = val[RotW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_regs(int w, int h, int t, int imp, int stl, int rot);
    write_reg(CFG_FRAME_WIDTH, CfgDataW'(w));
    write_reg(CFG_FRAME_HEIGHT, CfgDataW'(h));
    write_reg(CFG_ALIGN_TOL, CfgDataW'(t));
    write_reg(CFG_IMPACT_DIST, CfgDataW'(imp));
    write_reg(CFG_STILL_DIST, CfgDataW'(stl));
    write_reg(CFG_MAX_ROTATE, CfgDataW'(rot));
  endtask

  // Waits until every queued frame is in and every planned command is out,
  // then gives a frame that produced nothing time to leave the pipeline.
  task automatic settle();
    while (frame_queue.size() != 0 || s_axis_tvalid || planned_cmds.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Frame driver: holds a beat until it is taken, then waits its drawn gap
  // before presenting the next queued frame.
  always @(negedge clk_i) begin : frame_driver
    frame_t nxt;
    if (rst_ni && (!s_axis_tvalid || frame_taken)) begin
      frame_taken = 1'b0;
      if (frame_gap > 0) begin
        frame_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (frame_queue.size() != 0) begin
        nxt = frame_queue.pop_front();
        s_axis_tdata  <= InW'(nxt.pos);
        s_axis_tuser  <= nxt.seen;
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 47) == 0) in_steady = !in_steady;
        frame_gap = draw_gap(in_steady);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Command sink: after each beat it stalls for a drawn number of cycles, and
  // it also drops ready now and then at random unless it runs steady.
  always @(negedge clk_i) begin : cmd_sink
    if (rst_ni) begin
      if (cmd_taken) begin
        cmd_taken = 1'b0;
        if ($urandom_range(0, 47) == 0) out_steady = !out_steady;
        cmd_stall = draw_gap(out_steady);
      end
      if (cmd_stall > 0) begin
        cmd_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= out_steady || ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor: every accepted frame feeds the predictor, and every accepted
  // command beat is held against the oldest planned command.
  always @(posedge clk_i) begin : observe
    in_item_t pos;
    cmd_t     got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pos = s_axis_tdata[InFieldsW-1:0];
        plan_commands(s_axis_tuser, pos);
        frame_taken = 1'b1;
        frames_seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.mv    = move_e'(m_axis_tdata[MoveW-1:0]);
        got.hold  = m_axis_tdata[MoveW +: HoldW];
        got.last  = m_axis_tlast;
        cmd_taken = 1'b1;
        cmds_seen++;
        if (planned_cmds.size() == 0) begin
          $error("unplanned command beat: move %0d hold_ms %0d last %0b",
                 got.mv, got.hold, got.last);
          err_count++;
        end else begin
          want = planned_cmds.pop_front();
          if (got.mv !== want.mv) begin
            $error("move: expected %0d, got %0d", want.mv, got.mv);
            err_count++;
          end
          if (got.hold !== want.hold) begin
            $error("hold_ms: expected %0d, got %0d", want.hold, got.hold);
            err_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            err_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset settings (ring 640 x 480).
    // Missing opponent, body and tip, with the coordinates at their extremes.
    frame_queue.push_back(mk_frame(SeenNoOpp, CoordMax, CoordMax, CoordMax, CoordMax,
                                   CoordMax, CoordMax, 65535));
    frame_queue.push_back(mk_frame(SeenNoSelf, 0, 0, 0, 0, 0, 0, 0));
    frame_queue.push_back(mk_frame(SeenNoTip, 0, 0, 500, 500, 0, 0, 0));
    // Everything at one point: body and opponent coincide, so never aligned.
    frame_queue.push_back(mk_frame(SeenAll, 0, 0, 0, 0, 0, 0, 0));
    // Same at the far corner, with the rotation timer long expired.
    frame_queue.push_back(mk_frame(SeenAll, CoordMax, CoordMax, CoordMax, CoordMax,
                                   CoordMax, CoordMax, 65535));
    // Tip on the line in front of the body, then behind it.
    frame_queue.push_back(mk_frame(SeenAll, 300, 100, 100, 100, 120, 100, 10));
    frame_queue.push_back(mk_frame(SeenAll, 300, 100, 100, 100, 80, 100, 10));
    // Turning both ways until the rotation limit forces the attack.
    frame_queue.push_back(mk_frame(SeenAll, 300, 100, 100, 100, 100, 80, 20));
    frame_queue.push_back(mk_frame(SeenAll, 300, 100, 100, 100, 100, 120, 21));
    frame_queue.push_back(mk_frame(SeenAll, 300, 100, 100, 100, 100, 120, 23));
    frame_queue.push_back(mk_frame(SeenAll, 300, 100, 100, 100, 100, 120, 24));
    // Rotation that runs across the wrap of the seconds counter.
    frame_queue.push_back(mk_frame(SeenAll, 300, 100, 100, 100, 100, 80, 65534));
    frame_queue.push_back(mk_frame(SeenAll, 300, 100, 100, 100, 100, 80, 1));
    frame_queue.push_back(mk_frame(SeenAll, 300, 100, 100, 100, 100, 80, 2));
    // Contact with the body on the ring centre, backing up, then held while
    // still: the centre turn is mirrored and the push goes backward.
    frame_queue.push_back(mk_frame(SeenAll, 330, 240, 320, 240, 310, 240, 100));
    frame_queue.push_back(mk_frame(SeenAll, 330, 240, 320, 240, 310, 240, 101));
    // Contact broken, then a fresh contact facing forward and held.
    frame_queue.push_back(mk_frame(SeenAll, 600, 240, 320, 240, 340, 240, 102));
    frame_queue.push_back(mk_frame(SeenAll, 310, 210, 300, 200, 310, 200, 110));
    frame_queue.push_back(mk_frame(SeenAll, 310, 210, 300, 200, 310, 200, 111));
    // Opponent lost in the middle of a contact, then found again.
    frame_queue.push_back(mk_frame(SeenNoOpp, 310, 210, 300, 200, 310, 200, 112));
    frame_queue.push_back(mk_frame(SeenAll, 310, 210, 300, 200, 310, 200, 113));

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1: program_regs(CoordMax, CoordMax, 65535, CoordMax, CoordMax, 255);
        2: program_regs(1, 1, 0, 0, 0, 0);
        3: program_regs($urandom_range(200, 1200), $urandom_range(200, 1200),
                        $urandom_range(50, 2000), $urandom_range(10, 100),
                        $urandom_range(2, 40), $urandom_range(1, 8));
        // Full range, with the unused upper data bits set at random.
        4: program_regs(($urandom & 16'hF800) | $urandom_range(1, CoordMax),
                        ($urandom & 16'hF800) | $urandom_range(1, CoordMax),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
        5: begin
          for (int i = CfgFirstSpare; i < (1 << CfgIdxW); i++)
            write_reg(CfgIdxW'(i), CfgDataW'($urandom));
          program_regs(640, 480, 205, 40, 15, 4);
        end
        default: ;
      endcase
      sc_sx    = $urandom_range(0, CoordMax);
      sc_sy    = $urandom_range(0, CoordMax);
      sc_ox    = $urandom_range(0, CoordMax);
      sc_oy    = $urandom_range(0, CoordMax);
      sc_now   = $urandom_range(0, 65535);
      sc_close = $urandom_range(0, 1);
      repeat (PhaseFrames) frame_queue.push_back(scene_frame());
      settle();
    end

    $display("Covered %0d frames and %0d command beats (%0d contact pushes) across",
             frames_seen, cmds_seen, pushes_planned);
    $display("%0d register settings using %0d configuration writes.", NumPhases, cfg_writes);
    if (err_count == 0) begin
      $display("pursuit_robot_move_selector test passed");
    end else begin
      $display("pursuit_robot_move_selector test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutTicks);
    $display("pursuit_robot_move_selector test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/pmsel_pkg.sv
design/pmsel_cfg_regs.sv
design/pmsel_ctrl.sv
design/pmsel_datapath.sv
design/pursuit_robot_move_selector.sv
design/pmsel_checker.sv
dv/tb_pursuit_robot_move_selector.sv
